[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Each macro places one labeled concurrent assertion, clocked on the rising
// edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ugai_pkg.sv]
// ----------------------------------------------------------------------------
// ugai_pkg
// Shared types, codes and default sizes of the uniform grid insert block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ugai_pkg;

    localparam int GRID_ROWS_D      = 8;
    localparam int GRID_COLS_D      = 8;
    localparam int ENTITY_COUNT_D   = 64;
    localparam int SLOTS_PER_CELL_D = 8;

    localparam int MAX_RESULTS_K = 64;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS_K);

    localparam int COORD_W = 24;
    localparam int INV_W   = 24;
    localparam int FRAC_W  = 24;
    localparam logic [INV_W-1:0] INV_RESET = 24'd4096;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;

    localparam int EDGE_MIN_Y = 0;
    localparam int EDGE_MAX_Y = 1;
    localparam int EDGE_MIN_X = 2;
    localparam int EDGE_MAX_X = 3;
    localparam int EDGE_COUNT = 4;

    typedef struct packed {
        logic                      cmd;
        logic [5:0]                entity_id;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0] cell_row;
        logic [2:0] cell_col;
        logic [2:0] slot_index;
        logic [1:0] status;
        logic       last;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/core/ugai_ram.sv]
// ----------------------------------------------------------------------------
// ugai_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ugai_map.sv]
// ----------------------------------------------------------------------------
// ugai_map
// Maps the four box edges to grid rows and columns with one shared
// multiplier, one edge per cycle, followed by a floor and clamp stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ugai_map
    import ugai_pkg::*;
#(
    parameter int GRID_ROWS_P = GRID_ROWS_D,
    parameter int GRID_COLS_P = GRID_COLS_D,
    parameter int IDX_W       = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_in_item         i_item,
    input  wire logic [INV_W-1:0] i_inv,
    output logic                  o_done,
    output logic [IDX_W-1:0]      o_idx [EDGE_COUNT]
);

    localparam int ROW_CENTER = (GRID_ROWS_P - 1) / 2;
    localparam int COL_CENTER = (GRID_COLS_P - 1) / 2;
    localparam int PROD_W     = COORD_W + INV_W + 1;
    localparam int SUM_W      = COORD_W + 1;

    logic signed [COORD_W-1:0] r_coord [EDGE_COUNT];
    logic                      r_busy;
    logic [2:0]                r_mul_cnt;
    logic signed [PROD_W-1:0]  r_prod;
    logic [1:0]                r_prod_idx;
    logic                      r_prod_vld;
    logic                      r_done;
    logic [IDX_W-1:0]          r_idx [EDGE_COUNT];

    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_floor;
    logic signed [SUM_W-1:0]  w_center;
    logic signed [SUM_W-1:0]  w_count;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_clamped;
    logic                     w_is_row;

    assign w_prod = r_coord[r_mul_cnt[1:0]] * $signed({1'b0, i_inv});

    always_comb begin
        w_is_row = !r_prod_idx[1];
        w_floor  = SUM_W'(r_prod >>> FRAC_W);
        w_center = w_is_row ? SUM_W'(ROW_CENTER) : SUM_W'(COL_CENTER);
        w_count  = w_is_row ? SUM_W'(GRID_ROWS_P) : SUM_W'(GRID_COLS_P);
        w_sum    = w_floor + w_center;
        if (w_sum >= w_count) begin
            w_clamped = w_count - SUM_W'(1);
        end else if (w_sum < 0) begin
            w_clamped = '0;
        end else begin
            w_clamped = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_mul_cnt  <= '0;
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_coord[EDGE_MIN_Y] <= i_item.min_y;
                r_coord[EDGE_MAX_Y] <= i_item.max_y;
                r_coord[EDGE_MIN_X] <= i_item.min_x;
                r_coord[EDGE_MAX_X] <= i_item.max_x;
                r_busy              <= 1'b1;
                r_mul_cnt           <= '0;
                r_prod_vld          <= 1'b0;
            end else if (r_busy && r_mul_cnt < 3'(EDGE_COUNT)) begin
                r_prod     <= w_prod;
                r_prod_idx <= r_mul_cnt[1:0];
                r_prod_vld <= 1'b1;
                r_mul_cnt  <= r_mul_cnt + 3'd1;
            end else begin
                r_prod_vld <= 1'b0;
            end
            if (r_prod_vld) begin
                r_idx[r_prod_idx] <= w_clamped[IDX_W-1:0];
                if (r_prod_idx == 2'(EDGE_MAX_X)) begin
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

[rtl/core/uniform_grid_aabb_insert.sv]
// ----------------------------------------------------------------------------
// uniform_grid_aabb_insert
// Broadphase uniform grid insert. Clears the grid or writes an entity into
// the first free slot of every cell its box covers, one result per cell.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+--------------------------
//  in       | input     | valid / stall    | t_in_item (command, box)
//  out      | output    | valid / stall    | t_out_item (one per cell)
//  cfg      | input     | valid / ready    | inv_cell_size, 24 bits
//
//  An insert maps its edges through the one shared multiplier, then does
//  an occupancy RAM read-modify-write (S_READ, S_WRITE) for each covered
//  cell; an inverted box or bad id is taken and dropped with no result.
//  A clear, and reset, sweep the occupancy RAM one cell a cycle over all
//  GRID_ROWS_P * GRID_COLS_P cells (64 by default); no item is taken.
//  A stalled output holds its item and pauses the cell walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uniform_grid_aabb_insert
    import ugai_pkg::*;
#(
    parameter int GRID_ROWS_P    = GRID_ROWS_D,
    parameter int GRID_COLS_P    = GRID_COLS_D,
    parameter int ENTITY_COUNT   = ENTITY_COUNT_D,
    parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_D
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [INV_W-1:0] i_cfg_data
);

    localparam int NUM_CELLS = GRID_ROWS_P * GRID_COLS_P;
    localparam int MAX_N     = (GRID_ROWS_P > GRID_COLS_P) ? GRID_ROWS_P : GRID_COLS_P;
    localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SLOT_W    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int ENT_DEPTH = NUM_CELLS * SLOTS_PER_CELL;
    localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

    typedef enum logic [5:0] {
        S_SWEEP  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MAP    = 6'b000100,
        S_READ   = 6'b001000,
        S_WRITE  = 6'b010000,
        S_CLRRES = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [CELL_W-1:0]       r_sweep, n_sweep;
    logic                    r_clr_pend, n_clr_pend;
    logic [5:0]              r_ent, n_ent;
    logic [IDX_W-1:0]        r_row, n_row;
    logic [IDX_W-1:0]        r_col, n_col;
    logic [IDX_W-1:0]        r_top, n_top;
    logic [IDX_W-1:0]        r_left, n_left;
    logic [IDX_W-1:0]        r_right, n_right;
    logic [RES_CNT_W-1:0]    r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_item, n_out_item;
    logic [INV_W-1:0]        r_inv;

    logic                    w_accept;
    logic                    w_box_ok;
    logic                    w_map_start;
    logic                    w_map_done;
    logic [IDX_W-1:0]        w_idx [EDGE_COUNT];
    logic                    w_out_free;
    logic [CELL_W-1:0]       w_cell;
    logic                    w_occ_wr_en;
    logic [CELL_W-1:0]       w_occ_wr_addr;
    logic [SLOTS_PER_CELL-1:0] w_occ_wr_data;
    logic                    w_occ_rd_en;
    logic [SLOTS_PER_CELL-1:0] w_occ;
    logic                    w_ent_wr_en;
    logic [ENT_AW-1:0]       w_ent_addr;
    logic [SLOT_W-1:0]       w_free;
    logic                    w_found;
    logic                    w_last;
    logic [SLOT_W+2:0]       w_slot_ext;
    logic [IDX_W+2:0]        w_row_ext;
    logic [IDX_W+2:0]        w_col_ext;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_box_ok    = (int'(i_in_item.entity_id) < ENTITY_COUNT)
                      && (i_in_item.min_x <= i_in_item.max_x)
                      && (i_in_item.min_y <= i_in_item.max_y);
    assign w_map_start = w_accept && (i_in_item.cmd == CMD_INSERT) && w_box_ok;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cell      = CELL_W'(int'(r_row) * GRID_COLS_P + int'(r_col));
    assign w_ent_addr  = ENT_AW'(int'(w_cell) * SLOTS_PER_CELL + int'(w_free));
    assign w_last      = ((r_row == r_top) && (r_col == r_right))
                      || (r_cnt == RES_CNT_W'(MAX_RESULTS_K - 1));
    assign w_slot_ext  = (SLOT_W + 3)'(w_free);
    assign w_row_ext   = (IDX_W + 3)'(r_row);
    assign w_col_ext   = (IDX_W + 3)'(r_col);

    always_comb begin
        w_free  = '0;
        w_found = 1'b0;
        for (int s = SLOTS_PER_CELL - 1; s >= 0; s--) begin
            if (!w_occ[s]) begin
                w_free  = SLOT_W'(s);
                w_found = 1'b1;
            end
        end
    end

    ugai_map #(
        .GRID_ROWS_P(GRID_ROWS_P),
        .GRID_COLS_P(GRID_COLS_P),
        .IDX_W      (IDX_W)
    ) u_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_map_start),
        .i_item (i_in_item),
        .i_inv  (r_inv),
        .o_done (w_map_done),
        .o_idx  (w_idx)
    );

    ugai_ram #(
        .WIDTH(SLOTS_PER_CELL),
        .DEPTH(NUM_CELLS)
    ) u_occ_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_occ_wr_en),
        .i_wr_addr(w_occ_wr_addr),
        .i_wr_data(w_occ_wr_data),
        .i_rd_en  (w_occ_rd_en),
        .i_rd_addr(w_cell),
        .o_rd_data(w_occ)
    );

    ugai_ram #(
        .WIDTH(6),
        .DEPTH(ENT_DEPTH)
    ) u_ent_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_ent_wr_en),
        .i_wr_addr(w_ent_addr),
        .i_wr_data(r_ent),
        .i_rd_en  (1'b0),
        .i_rd_addr(w_ent_addr),
        .o_rd_data()
    );

    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_clr_pend    = r_clr_pend;
        n_ent         = r_ent;
        n_row         = r_row;
        n_col         = r_col;
        n_top         = r_top;
        n_left        = r_left;
        n_right       = r_right;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_item    = r_out_item;
        w_occ_wr_en   = 1'b0;
        w_occ_wr_addr = w_cell;
        w_occ_wr_data = w_occ | (SLOTS_PER_CELL'(1) << w_free);
        w_occ_rd_en   = 1'b0;
        w_ent_wr_en   = 1'b0;
        case (r_state)
            S_SWEEP: begin
                w_occ_wr_en   = 1'b1;
                w_occ_wr_addr = r_sweep;
                w_occ_wr_data = '0;
                if (r_sweep == CELL_W'(NUM_CELLS - 1)) begin
                    n_state = r_clr_pend ? S_CLRRES : S_IDLE;
                end else begin
                    n_sweep = r_sweep + CELL_W'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.cmd == CMD_CLEAR) begin
                        n_state    = S_SWEEP;
                        n_sweep    = '0;
                        n_clr_pend = 1'b1;
                    end else if (w_box_ok) begin
                        n_state = S_MAP;
                        n_ent   = i_in_item.entity_id;
                    end
                end
            end
            S_MAP: begin
                if (w_map_done) begin
                    n_row   = w_idx[EDGE_MIN_Y];
                    n_top   = w_idx[EDGE_MAX_Y];
                    n_left  = w_idx[EDGE_MIN_X];
                    n_col   = w_idx[EDGE_MIN_X];
                    n_right = w_idx[EDGE_MAX_X];
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_occ_rd_en = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                if (w_out_free) begin
                    w_occ_wr_en           = w_found;
                    w_ent_wr_en           = w_found;
                    n_out_valid           = 1'b1;
                    n_out_item.cell_row   = w_row_ext[2:0];
                    n_out_item.cell_col   = w_col_ext[2:0];
                    n_out_item.slot_index = w_found ? w_slot_ext[2:0] : 3'd0;
                    n_out_item.status     = w_found ? ST_STORED : ST_FULL;
                    n_out_item.last       = w_last;
                    n_cnt                 = r_cnt + RES_CNT_W'(1);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_READ;
                        if (r_col == r_right) begin
                            n_col = r_left;
                            n_row = r_row + IDX_W'(1);
                        end else begin
                            n_col = r_col + IDX_W'(1);
                        end
                    end
                end
            end
            S_CLRRES: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_item.cell_row   = 3'd0;
                    n_out_item.cell_col   = 3'd0;
                    n_out_item.slot_index = 3'd0;
                    n_out_item.status     = ST_CLEARED;
                    n_out_item.last       = 1'b1;
                    n_clr_pend            = 1'b0;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_clr_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_inv       <= INV_RESET;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_clr_pend  <= n_clr_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_inv <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_row      <= n_row;
        r_col      <= n_col;
        r_top      <= n_top;
        r_left     <= n_left;
        r_right    <= n_right;
        r_cnt      <= n_cnt;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/core/ugai_checker.sv]
// ----------------------------------------------------------------------------
// ugai_checker
// Port-level checks of the uniform grid insert block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ugai_checker
    import ugai_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid, "stalled output item dropped")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
        $stable(o_out_item), "stalled output item changed")
    `ASSERT_SAME(a_clear_fields, i_clk, i_rst_n,
        o_out_valid && o_out_item.status == ST_CLEARED,
        o_out_item.last && o_out_item.cell_row == 3'd0 && o_out_item.cell_col == 3'd0
            && o_out_item.slot_index == 3'd0,
        "clear result fields wrong")
    `ASSERT_SAME(a_full_slot, i_clk, i_rst_n, o_out_valid && o_out_item.status == ST_FULL,
        o_out_item.slot_index == 3'd0, "dropped result carries a slot")

endmodule

bind uniform_grid_aabb_insert ugai_checker u_ugai_checker (.*);

`default_nettype wire

[tb/uniform_grid_aabb_insert_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_aabb_insert_test
// Drives clear and insert commands into the grid insert block and compares
// every cell update it emits against a behavioral grid kept in the bench.
// Directed commands cover clears, full cells, whole-grid boxes, inverted
// boxes, cell boundaries and the register extremes; random boxes follow
// under several cell sizes, with bursty input and a randomly stalled output.
// ----------------------------------------------------------------------------

module uniform_grid_aabb_insert_test;
    import ugai_pkg::*;

    localparam int LIMIT_CYCLES    = 2000000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int NUM_CELLS       = GRID_ROWS_D * GRID_COLS_D;
    localparam longint COORD_HI    = 64'sd8388607;
    localparam longint COORD_LO    = -64'sd8388608;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_in_item         i_in_item   = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [INV_W-1:0] i_cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_item;
    logic             o_cfg_ready;

    logic [SLOTS_PER_CELL_D-1:0] occupancy [NUM_CELLS];
    logic [INV_W-1:0]            inv_cell_reg = INV_RESET;
    t_out_item                   cell_updates_q [$];
    t_out_item                   expected_update;
    int                          error_count     = 0;
    int                          cycle_count     = 0;
    int                          burst_left      = 0;
    int                          stall_mode      = 0;
    int                          stall_mode_left = 0;
    int                          stall_phase     = 0;

    uniform_grid_aabb_insert dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int cell_index(logic signed [COORD_W-1:0] coord, int n);
        longint prod;
        longint idx;
        prod = longint'(coord) * longint'(inv_cell_reg);
        idx = longint'((n - 1) / 2) + (prod >>> FRAC_W);
        if (idx >= n) begin
            return n - 1;
        end
        if (idx < 0) begin
            return 0;
        end
        return int'(idx);
    endfunction

    function automatic void predict_command(t_in_item it);
        int        bot, top, left, right, cell_num, slot, count;
        bit        stored;
        t_out_item res;
        res = '0;
        if (it.cmd == CMD_CLEAR) begin
            foreach (occupancy[i]) occupancy[i] = '0;
            res.status = ST_CLEARED;
            res.last = 1'b1;
            cell_updates_q.push_back(res);
            return;
        end
        if (it.entity_id >= ENTITY_COUNT_D || it.min_x > it.max_x || it.min_y > it.max_y) begin
            return;
        end
        bot   = cell_index(it.min_y, GRID_ROWS_D);
        top   = cell_index(it.max_y, GRID_ROWS_D);
        left  = cell_index(it.min_x, GRID_COLS_D);
        right = cell_index(it.max_x, GRID_COLS_D);
        count = 0;
        for (int row = bot; row <= top && count < MAX_RESULTS_K; row++) begin
            for (int col = left; col <= right && count < MAX_RESULTS_K; col++) begin
                cell_num = row * GRID_COLS_D + col;
                stored = 1'b0;
                slot = 0;
                for (int s = 0; s < SLOTS_PER_CELL_D && !stored; s++) begin
                    if (!occupancy[cell_num][s]) begin
                        occupancy[cell_num][s] = 1'b1;
                        slot = s;
                        stored = 1'b1;
                    end
                end
                res.cell_row   = 3'(row);
                res.cell_col   = 3'(col);
                res.slot_index = stored ? 3'(slot) : 3'd0;
                res.status     = stored ? ST_STORED : ST_FULL;
                res.last       = 1'b0;
                cell_updates_q.push_back(res);
                count++;
            end
        end
        if (count > 0) begin
            cell_updates_q[cell_updates_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_HI) begin
            return 24'sh7FFFFF;
        end
        if (v < COORD_LO) begin
            return 24'sh800000;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic t_in_item insert_box(int ent, longint x0, longint y0,
                                            longint x1, longint y1);
        t_in_item it;
        it.cmd       = CMD_INSERT;
        it.entity_id = 6'(ent);
        it.min_x     = clamp_coord(x0);
        it.min_y     = clamp_coord(y0);
        it.max_x     = clamp_coord(x1);
        it.max_y     = clamp_coord(y1);
        return it;
    endfunction

    function automatic t_in_item clear_command();
        t_in_item it;
        it.cmd       = CMD_CLEAR;
        it.entity_id = 6'($urandom);
        it.min_x     = COORD_W'($urandom);
        it.min_y     = COORD_W'($urandom);
        it.max_x     = COORD_W'($urandom);
        it.max_y     = COORD_W'($urandom);
        return it;
    endfunction

    // Width of one cell in raw coordinate units, or 0 when it exceeds 2^22 units.
    function automatic longint cell_width();
        longint w;
        if (inv_cell_reg == '0) begin
            return 0;
        end
        w = (64'sd1 << FRAC_W) / longint'(inv_cell_reg);
        return (w > (64'sd1 << 22)) ? 0 : w;
    endfunction

    function automatic longint pick_coord(longint w);
        if (w == 0) begin
            return longint'(clamp_coord(longint'($urandom_range(0, 24'hFFFFFF)) + COORD_LO));
        end
        return (longint'($urandom_range(0, 9)) - 4) * w + longint'($urandom_range(0, 32'(w - 1)));
    endfunction

    function automatic longint pick_extent(longint w);
        int r;
        r = $urandom_range(0, 99);
        if (w == 0 || r >= 92) begin
            return longint'($urandom_range(0, 24'hFFFFFF));
        end
        if (r < 70) begin
            return longint'($urandom_range(0, 32'(w)));
        end
        return longint'($urandom_range(0, 32'(3 * w)));
    endfunction

    function automatic t_in_item random_command();
        t_in_item it;
        longint   w, x0, y0;
        int       r;
        w = cell_width();
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return clear_command();
        end
        if (r < 14) begin
            it = clear_command();
            it.cmd = CMD_INSERT;
            return it;
        end
        x0 = pick_coord(w);
        y0 = pick_coord(w);
        it = insert_box($urandom_range(0, ENTITY_COUNT_D - 1), x0, y0,
                        x0 + pick_extent(w), y0 + pick_extent(w));
        if (r < 18) begin
            it.max_x = clamp_coord(longint'(it.min_x) - 1 - longint'($urandom_range(0, 300)));
        end else if (r < 22) begin
            it.max_y = clamp_coord(longint'(it.min_y) - 1 - longint'($urandom_range(0, 300)));
        end
        return it;
    endfunction

    task automatic send_command(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_command(it);
    endtask

    task automatic pause_sender(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (cell_updates_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_inv_cell(logic [INV_W-1:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        inv_cell_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(string what, t_out_item want, t_out_item got);
        error_count++;
        if (error_count <= 10) begin
            $display("%s: expected row %0d col %0d slot %0d status %0d last %0d, ",
                     what, want.cell_row, want.cell_col, want.slot_index, want.status,
                     want.last,
                     "got row %0d col %0d slot %0d status %0d last %0d",
                     got.cell_row, got.cell_col, got.slot_index, got.status, got.last);
        end
    endtask

    task automatic test_clear();
        send_command(clear_command());
    endtask

    task automatic test_full_cell();
        for (int i = 0; i < SLOTS_PER_CELL_D + 1; i++) begin
            send_command(insert_box(i, 100, 100, 200, 300));
        end
    endtask

    task automatic test_grid_span();
        send_command(insert_box(ENTITY_COUNT_D - 1, COORD_LO, COORD_LO, COORD_HI, COORD_HI));
        send_command(clear_command());
    endtask

    task automatic test_inverted_box();
        send_command(insert_box(5, 1, 0, 0, 10));
        send_command(insert_box(6, 0, 1, 10, 0));
        send_command(insert_box(7, -1, -1, -1, -1));
    endtask

    task automatic test_cell_boundaries();
        send_command(insert_box(0, -4096, -4097, 4095, 4096));
        send_command(insert_box(9, -1, -1, 0, 0));
    endtask

    task automatic test_register_extremes();
        write_inv_cell('0);
        send_command(insert_box(11, COORD_LO, COORD_LO, COORD_HI, COORD_HI));
        write_inv_cell(24'd1);
        send_command(insert_box(12, COORD_LO, COORD_LO, COORD_HI, COORD_HI));
        write_inv_cell(24'hFFFFFF);
        send_command(insert_box(13, -5, -5, 5, 5));
        send_command(clear_command());
    endtask

    task automatic test_random_boxes();
        logic [INV_W-1:0] scales [6];
        scales = '{INV_RESET, 24'd65536, 24'hFFFFFF, 24'd1,
                   INV_W'($urandom_range(1, 24'hFFFFFF)), 24'd2048};
        foreach (scales[p]) begin
            write_inv_cell(scales[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 39) == 0) begin
                    wait_idle();
                end
                send_command(random_command());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(32, 200);
        end else begin
            stall_mode_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_out_stall <= ((stall_phase % 8) < 3);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cell_updates_q.size() == 0) begin
                flag_mismatch("unexpected cell update", '0, o_out_item);
            end else begin
                expected_update = cell_updates_q.pop_front();
                if (o_out_item.cell_row !== expected_update.cell_row
                        || o_out_item.cell_col !== expected_update.cell_col
                        || o_out_item.slot_index !== expected_update.slot_index
                        || o_out_item.status !== expected_update.status
                        || o_out_item.last !== expected_update.last) begin
                    flag_mismatch("cell update mismatch", expected_update, o_out_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL uniform_grid_aabb_insert");
            $finish;
        end
    end

    initial begin
        foreach (occupancy[i]) occupancy[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_clear();
        test_full_cell();
        test_grid_span();
        test_inverted_box();
        test_cell_boundaries();
        test_register_extremes();
        test_random_boxes();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && cell_updates_q.size() == 0) begin
            $display("PASS uniform_grid_aabb_insert");
        end else begin
            $display("FAIL uniform_grid_aabb_insert");
        end
        $finish;
    end

endmodule
